// File: hdl/dmc_pkg.sv
package dmc_pkg;

    localparam int PULSE_W     = 12;
    localparam int SPEED_W     = 8;
    localparam int HALF_W      = 11;
    localparam int PROD_W      = SPEED_W + HALF_W;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 20;
    localparam int CMDQ_DEPTH  = 2;
    localparam int RESQ_DEPTH  = 4;

    // floor(2^20 / 255); estimate is exact or one low for 19-bit products
    localparam logic [RECIP_W-1:0] RECIP      = 13'd4112;
    localparam logic [PROD_W-1:0]  SPEED_FULL = 19'd255;

    localparam logic [2:0] FUNC_SPEED = 3'd0;
    localparam logic [2:0] FUNC_DIR   = 3'd1;
    localparam logic [2:0] FUNC_BOTH  = 3'd2;
    localparam logic [2:0] FUNC_DIFF  = 3'd3;
    localparam logic [2:0] FUNC_STOP  = 3'd4;

    localparam logic [1:0] DIR_FWD   = 2'd0;
    localparam logic [1:0] DIR_BWD   = 2'd1;
    localparam logic [1:0] DIR_STOP  = 2'd2;
    localparam logic [1:0] DIR_BRAKE = 2'd3;

    localparam logic [1:0] CFG_ENABLE = 2'd0;
    localparam logic [1:0] CFG_PMIN   = 2'd1;
    localparam logic [1:0] CFG_PMAX   = 2'd2;

    // slot bits in issue order: 0 dir m0, 1 speed m0, 2 dir m1, 3 speed m1
    typedef struct packed {
        logic [3:0]         slots;
        logic [1:0]         dir1;
        logic [1:0]         dir0;
        logic [SPEED_W-1:0] spd1;
        logic [SPEED_W-1:0] spd0;
    } cmd_t;

    typedef struct packed {
        logic               valid;
        logic               chan;
        logic [1:0]         dir;
        logic [SPEED_W-1:0] speed;
        logic               last;
    } op_t;

    typedef struct packed {
        logic               chan;
        logic [PULSE_W-1:0] pulse;
        logic               last;
    } res_t;

endpackage

// File: hdl/dmc_front.sv
module dmc_front
    import dmc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         enable,
    input  logic         push,
    output logic         full,
    input  logic [2:0]   func,
    input  logic [7:0]   motor_mask,
    input  logic [7:0]   speed_a,
    input  logic [7:0]   speed_b,
    input  logic [7:0]   dir_a,
    input  logic [7:0]   dir_b,
    input  logic         q_pop,
    output logic         q_empty,
    output cmd_t         q_head
);

    localparam int CQ_AW = $clog2(CMDQ_DEPTH);
    localparam int CQ_CW = $clog2(CMDQ_DEPTH + 1);

    cmd_t             dec;
    logic             sel0;
    logic             sel1;
    logic             dv0;
    logic             dv1;
    logic             wr;
    logic             rd;

    cmd_t             mem_reg [CMDQ_DEPTH];
    logic [CQ_AW-1:0] wptr_reg;
    logic [CQ_AW-1:0] wptr_next;
    logic [CQ_AW-1:0] rptr_reg;
    logic [CQ_AW-1:0] rptr_next;
    logic [CQ_CW-1:0] cnt_reg;
    logic [CQ_CW-1:0] cnt_next;

    always_comb
    begin
        sel0 = motor_mask[0] | (func == FUNC_DIFF);
        sel1 = motor_mask[1] | (func == FUNC_DIFF);
        dv0  = (dir_a[7:2] == 6'd0);
        dv1  = (dir_b[7:2] == 6'd0);
        dec.dir0  = dir_a[1:0];
        dec.dir1  = dir_b[1:0];
        dec.spd0  = speed_a;
        dec.spd1  = speed_b;
        dec.slots = 4'b0000;
        unique case (func)
            FUNC_SPEED:
            begin
                dec.slots = {sel1, 1'b0, sel0, 1'b0};
            end
            FUNC_DIR:
            begin
                dec.slots = {1'b0, sel1 & dv1, 1'b0, sel0 & dv0};
            end
            FUNC_BOTH, FUNC_DIFF:
            begin
                dec.slots = {sel1, sel1 & dv1, sel0, sel0 & dv0};
            end
            FUNC_STOP:
            begin
                dec.slots = 4'b1111;
                dec.dir0  = DIR_STOP;
                dec.dir1  = DIR_STOP;
                dec.spd0  = '0;
                dec.spd1  = '0;
            end
            default:
            begin
                dec.slots = 4'b0000;
            end
        endcase
        if (!enable)
        begin
            dec.slots = 4'b0000;
        end
    end

    assign full    = (cnt_reg == CQ_CW'(CMDQ_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign q_head  = mem_reg[rptr_reg];

    // commands that update nothing are taken and dropped here
    assign wr = push && !full && (dec.slots != 4'b0000);
    assign rd = q_pop && !q_empty;

    always_comb
    begin
        wptr_next = wr ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = rd ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg + CQ_CW'(wr) - CQ_CW'(rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wptr_reg] <= dec;
        end
    end

endmodule

// File: hdl/dmc_back.sv
module dmc_back
    import dmc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_empty,
    input  cmd_t q_head,
    output logic q_pop,
    input  logic room,
    output op_t  op
);

    logic [3:0]         pend_reg;
    logic [3:0]         pend_next;
    cmd_t               cur_reg;
    logic [1:0]         dir_reg [2];
    logic [SPEED_W-1:0] spd_reg [2];

    logic [1:0]         k;
    logic [3:0]         rest;
    logic               issue;
    logic               done;
    logic               chan;
    logic [1:0]         new_dir;
    logic [SPEED_W-1:0] new_spd;

    always_comb
    begin
        priority if (pend_reg[0])
        begin
            k = 2'd0;
        end
        else if (pend_reg[1])
        begin
            k = 2'd1;
        end
        else if (pend_reg[2])
        begin
            k = 2'd2;
        end
        else
        begin
            k = 2'd3;
        end
    end

    assign rest  = pend_reg & ~(4'b0001 << k);
    assign issue = (pend_reg != 4'b0000) && room;
    assign done  = (pend_reg == 4'b0000) || (issue && (rest == 4'b0000));
    assign q_pop = done && !q_empty;
    assign chan  = k[1];

    always_comb
    begin
        if (k[0])
        begin
            new_dir = dir_reg[chan];
            new_spd = chan ? cur_reg.spd1 : cur_reg.spd0;
        end
        else
        begin
            new_dir = chan ? cur_reg.dir1 : cur_reg.dir0;
            new_spd = spd_reg[chan];
        end
    end

    always_comb
    begin
        op.valid = issue;
        op.chan  = chan;
        op.dir   = new_dir;
        op.speed = new_spd;
        op.last  = (rest == 4'b0000);
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (q_pop)
        begin
            pend_next = q_head.slots;
        end
        else if (issue)
        begin
            pend_next = rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg   <= 4'b0000;
            dir_reg[0] <= DIR_STOP;
            dir_reg[1] <= DIR_STOP;
            spd_reg[0] <= '0;
            spd_reg[1] <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (issue)
            begin
                dir_reg[chan] <= new_dir;
                spd_reg[chan] <= new_spd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_head;
        end
    end

endmodule

// File: hdl/dmc_pulse.sv
module dmc_pulse
    import dmc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  op_t                op,
    output logic               room,
    input  logic [PULSE_W-1:0] pulse_min,
    input  logic [PULSE_W-1:0] pulse_max,
    output logic               empty,
    input  logic               pop,
    output logic               channel,
    output logic [PULSE_W-1:0] pulse,
    output logic               last
);

    localparam int RQ_AW = $clog2(RESQ_DEPTH);
    localparam int RQ_CW = $clog2(RESQ_DEPTH + 1);
    localparam int EST_W = PROD_W + RECIP_W;

    logic [PULSE_W:0]   nsum;
    logic [PULSE_W-1:0] neutral;
    logic [PULSE_W-1:0] diff;
    logic [HALF_W-1:0]  half;

    logic               v1_reg;
    logic               ch1_reg;
    logic [1:0]         dir1_reg;
    logic               last1_reg;
    logic [PROD_W-1:0]  prod1_reg;

    logic               v2_reg;
    logic               ch2_reg;
    logic [1:0]         dir2_reg;
    logic               last2_reg;
    logic [PROD_W-1:0]  prod2_reg;
    logic [PULSE_W-1:0] q2_reg;

    logic [EST_W-1:0]   est;
    logic [PROD_W:0]    q255;
    logic [PROD_W-1:0]  rem;
    logic [PULSE_W-1:0] offset;
    res_t               res;

    res_t               mem_reg [RESQ_DEPTH];
    logic [RQ_AW-1:0]   wptr_reg;
    logic [RQ_AW-1:0]   rptr_reg;
    logic [RQ_CW-1:0]   fcnt_reg;
    logic [RQ_CW-1:0]   fcnt_next;
    logic [RQ_CW-1:0]   cred_reg;
    logic [RQ_CW-1:0]   cred_next;
    logic               pop_ok;

    assign nsum    = {1'b0, pulse_min} + {1'b0, pulse_max};
    assign neutral = nsum[PULSE_W:1];
    assign diff    = pulse_max - pulse_min;
    assign half    = (pulse_max >= pulse_min) ? diff[PULSE_W-1:1] : '0;

    // offset = floor(speed * half / 255): reciprocal estimate, then one correction
    assign est    = EST_W'(prod1_reg) * EST_W'(RECIP);
    assign q255   = {(PROD_W+1-PULSE_W)'(0), q2_reg} * (PROD_W+1)'(SPEED_FULL);
    assign rem    = prod2_reg - q255[PROD_W-1:0];
    assign offset = (rem >= SPEED_FULL) ? q2_reg + 1'b1 : q2_reg;

    always_comb
    begin
        res.chan = ch2_reg;
        res.last = last2_reg;
        unique case (dir2_reg)
            DIR_FWD:   res.pulse = neutral + offset;
            DIR_BWD:   res.pulse = neutral - offset;
            DIR_STOP:  res.pulse = neutral;
            DIR_BRAKE: res.pulse = neutral;
            default:   res.pulse = neutral;
        endcase
    end

    assign pop_ok    = pop && !empty;
    assign empty     = (fcnt_reg == '0);
    assign room      = (cred_reg < RQ_CW'(RESQ_DEPTH));
    assign fcnt_next = fcnt_reg + RQ_CW'(v2_reg) - RQ_CW'(pop_ok);
    assign cred_next = cred_reg + RQ_CW'(op.valid) - RQ_CW'(pop_ok);

    assign channel = mem_reg[rptr_reg].chan;
    assign pulse   = mem_reg[rptr_reg].pulse;
    assign last    = mem_reg[rptr_reg].last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            wptr_reg <= '0;
            rptr_reg <= '0;
            fcnt_reg <= '0;
            cred_reg <= '0;
        end
        else
        begin
            v1_reg   <= op.valid;
            v2_reg   <= v1_reg;
            fcnt_reg <= fcnt_next;
            cred_reg <= cred_next;
            if (v2_reg)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop_ok)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ch1_reg   <= op.chan;
        dir1_reg  <= op.dir;
        last1_reg <= op.last;
        prod1_reg <= PROD_W'(op.speed) * PROD_W'(half);
        ch2_reg   <= ch1_reg;
        dir2_reg  <= dir1_reg;
        last2_reg <= last1_reg;
        prod2_reg <= prod1_reg;
        q2_reg    <= est[RECIP_SHIFT +: PULSE_W];
        if (v2_reg)
        begin
            mem_reg[wptr_reg] <= res;
        end
    end

endmodule

// File: hdl/dual_motor_command_to_servo_pulse.sv
// Two-motor command to servo pulse converter.
// Command channel: push/full. A word (func, motor_mask, speeds, directions)
// is taken on a clock edge with push high and full low.
// Result channel: empty/pop. While empty is low the oldest pulse word
// (channel, pulse, last) is on the ports; pop high takes it. last marks the
// final word of a command. Commands that update nothing give no words.
// Configuration: cfg_valid/cfg_ready with cfg_addr (0 enable, 1 pulse_min,
// 2 pulse_max) and cfg_wdata; cfg_ready is always high. Write only when idle.
// The first word of a command passes the command queue, the sequencer's
// pend/cur registers, the v1/v2 pipeline registers and the result queue.
// Throughput: one result word per cycle while the result queue has room,
// set by the single-issue sequencer, which issues a command's 1 to 4 words.
// A two-entry command queue and a four-word result queue decouple both sides;
// when pop stays low, the result queue fills, the sequencer halts, and full
// rises once the command queue is full.
// Reset: driver disabled, limits 205/410, both motors stopped at speed zero,
// queues empty.
module dual_motor_command_to_servo_pulse
    import dmc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         func,
    input  logic [7:0]         motor_mask,
    input  logic [7:0]         speed_a,
    input  logic [7:0]         speed_b,
    input  logic [7:0]         dir_a,
    input  logic [7:0]         dir_b,
    output logic               empty,
    input  logic               pop,
    output logic               channel,
    output logic [PULSE_W-1:0] pulse,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_addr,
    input  logic [PULSE_W-1:0] cfg_wdata
);

    logic               enable_reg;
    logic [PULSE_W-1:0] pmin_reg;
    logic [PULSE_W-1:0] pmax_reg;

    logic               q_pop;
    logic               q_empty;
    cmd_t               q_head;
    logic               room;
    op_t                op;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            pmin_reg   <= 12'd205;
            pmax_reg   <= 12'd410;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_addr)
                CFG_ENABLE: enable_reg <= cfg_wdata[0];
                CFG_PMIN:   pmin_reg   <= cfg_wdata;
                CFG_PMAX:   pmax_reg   <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    dmc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (enable_reg),
        .push       (push),
        .full       (full),
        .func       (func),
        .motor_mask (motor_mask),
        .speed_a    (speed_a),
        .speed_b    (speed_b),
        .dir_a      (dir_a),
        .dir_b      (dir_b),
        .q_pop      (q_pop),
        .q_empty    (q_empty),
        .q_head     (q_head)
    );

    dmc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .room    (room),
        .op      (op)
    );

    dmc_pulse u_pulse (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .room      (room),
        .pulse_min (pmin_reg),
        .pulse_max (pmax_reg),
        .empty     (empty),
        .pop       (pop),
        .channel   (channel),
        .pulse     (pulse),
        .last      (last)
    );

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import dmc_pkg::*;

    localparam int unsigned SPEED_MAX = 255;
    localparam int DRAIN_CYCLES = 12;
    localparam int STOP_NS = 2000000;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] mask;
        logic [7:0] speed_a;
        logic [7:0] speed_b;
        logic [7:0] dir_a;
        logic [7:0] dir_b;
    } motor_cmd_t;

    class pulse_scoreboard;
        logic       enable;
        logic [11:0] pulse_min;
        logic [11:0] pulse_max;
        logic [1:0] dir_st[2];
        logic [7:0] speed_st[2];
        res_t       pulse_q[$];
        int         errors;

        function new();
            enable = 1'b0;
            pulse_min = 12'd205;
            pulse_max = 12'd410;
            for (int m = 0; m < 2; m++)
            begin
                dir_st[m] = DIR_STOP;
                speed_st[m] = 8'd0;
            end
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] addr, logic [11:0] data);
            case (addr)
                CFG_ENABLE: enable = data[0];
                CFG_PMIN:   pulse_min = data;
                CFG_PMAX:   pulse_max = data;
                default: ;
            endcase
        endfunction

        function void queue_pulse(int m);
            int unsigned lo;
            int unsigned hi;
            int unsigned neutral;
            int unsigned half;
            int unsigned offset;
            int unsigned p;
            res_t r;
            lo = pulse_min;
            hi = pulse_max;
            neutral = (lo + hi) / 2;
            half = (hi >= lo) ? (hi - lo) / 2 : 0;
            offset = (speed_st[m] * half) / SPEED_MAX;
            case (dir_st[m])
                DIR_FWD: p = neutral + offset;
                DIR_BWD: p = neutral - offset;
                default: p = neutral;
            endcase
            r.chan = m[0];
            r.pulse = p[11:0];
            r.last = 1'b0;
            pulse_q.push_back(r);
        endfunction

        function void apply_dir(int m, logic [7:0] d);
            if (d > 8'(DIR_BRAKE))
                return;
            dir_st[m] = d[1:0];
            queue_pulse(m);
        endfunction

        function void apply_speed(int m, logic [7:0] s);
            speed_st[m] = s;
            queue_pulse(m);
        endfunction

        function void note_command(motor_cmd_t c);
            logic [7:0] mask;
            logic [7:0] spd[2];
            logic [7:0] dr[2];
            int         before_n;
            res_t       tail;
            before_n = pulse_q.size();
            if (!enable)
                return;
            mask = (c.func == FUNC_DIFF) ? 8'hFF : c.mask;
            spd[0] = c.speed_a;
            spd[1] = c.speed_b;
            dr[0] = c.dir_a;
            dr[1] = c.dir_b;
            for (int m = 0; m < 2; m++)
            begin
                case (c.func)
                    FUNC_SPEED:
                        if (mask[m])
                            apply_speed(m, spd[m]);
                    FUNC_DIR:
                        if (mask[m])
                            apply_dir(m, dr[m]);
                    FUNC_BOTH, FUNC_DIFF:
                        if (mask[m])
                        begin
                            apply_dir(m, dr[m]);
                            apply_speed(m, spd[m]);
                        end
                    FUNC_STOP:
                    begin
                        apply_dir(m, 8'(DIR_STOP));
                        apply_speed(m, 8'd0);
                    end
                    default: ;
                endcase
            end
            if (pulse_q.size() > before_n)
            begin
                tail = pulse_q.pop_back();
                tail.last = 1'b1;
                pulse_q.push_back(tail);
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (pulse_q.size() == 0)
            begin
                errors++;
                $error("unexpected word: channel %0d pulse %0d last %0d",
                       got.chan, got.pulse, got.last);
                return;
            end
            want = pulse_q.pop_front();
            if (got.chan !== want.chan)
            begin
                errors++;
                $error("channel: expected %0d, got %0d", want.chan, got.chan);
            end
            if (got.pulse !== want.pulse)
            begin
                errors++;
                $error("pulse: expected %0d, got %0d", want.pulse, got.pulse);
            end
            if (got.last !== want.last)
            begin
                errors++;
                $error("last: expected %0d, got %0d", want.last, got.last);
            end
        endfunction

        function int outstanding();
            return pulse_q.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [2:0]         func;
    logic [7:0]         motor_mask;
    logic [7:0]         speed_a;
    logic [7:0]         speed_b;
    logic [7:0]         dir_a;
    logic [7:0]         dir_b;
    logic               empty;
    logic               pop;
    logic               channel;
    logic [PULSE_W-1:0] pulse;
    logic               last;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_addr;
    logic [PULSE_W-1:0] cfg_wdata;

    pulse_scoreboard sb;
    motor_cmd_t      seen_cmd;
    res_t            seen_res;
    int              tx_idle_pct;
    int              rx_stall_pct;

    dual_motor_command_to_servo_pulse dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .func       (func),
        .motor_mask (motor_mask),
        .speed_a    (speed_a),
        .speed_b    (speed_b),
        .dir_a      (dir_a),
        .dir_b      (dir_b),
        .empty      (empty),
        .pop        (pop),
        .channel    (channel),
        .pulse      (pulse),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #STOP_NS;
        $display("tb_top: errors");
        $finish;
    end

    always @(posedge clk)
    begin
        pop <= rst_n && ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                seen_cmd.func = func;
                seen_cmd.mask = motor_mask;
                seen_cmd.speed_a = speed_a;
                seen_cmd.speed_b = speed_b;
                seen_cmd.dir_a = dir_a;
                seen_cmd.dir_b = dir_b;
                sb.note_command(seen_cmd);
            end
            if (pop && !empty)
            begin
                seen_res.chan = channel;
                seen_res.pulse = pulse;
                seen_res.last = last;
                sb.check_result(seen_res);
            end
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_addr, cfg_wdata);
        end
    end

    function automatic motor_cmd_t mk_cmd(logic [2:0] f, logic [7:0] m,
                                          logic [7:0] sa, logic [7:0] sb_,
                                          logic [7:0] da, logic [7:0] db);
        motor_cmd_t c;
        c.func = f;
        c.mask = m;
        c.speed_a = sa;
        c.speed_b = sb_;
        c.dir_a = da;
        c.dir_b = db;
        return c;
    endfunction

    function automatic logic [7:0] rand_speed();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return 8'd0;
        if (pick < 16)
            return 8'd255;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] rand_dir();
        if ($urandom_range(99) < 85)
            return 8'($urandom_range(3));
        return 8'($urandom);
    endfunction

    function automatic motor_cmd_t rand_cmd();
        motor_cmd_t c;
        c.func = ($urandom_range(99) < 90) ? 3'($urandom_range(4)) : 3'($urandom_range(7, 5));
        c.mask = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
        c.speed_a = rand_speed();
        c.speed_b = rand_speed();
        c.dir_a = rand_dir();
        c.dir_b = rand_dir();
        return c;
    endfunction

    task automatic send_cmd(motor_cmd_t c);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        func <= c.func;
        motor_mask <= c.mask;
        speed_a <= c.speed_a;
        speed_b <= c.speed_b;
        dir_a <= c.dir_a;
        dir_b <= c.dir_b;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic drain();
        push <= 1'b0;
        // let the monitor note the last accepted word first
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic [1:0] addr, logic [11:0] data);
        cfg_valid <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_limits(logic [11:0] lo, logic [11:0] hi);
        cfg_write(CFG_PMIN, lo);
        cfg_write(CFG_PMAX, hi);
    endtask

    task automatic run_random(int n);
        repeat (n) send_cmd(rand_cmd());
    endtask

    initial
    begin
        sb = new();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rst_n <= 1'b0;
        push <= 1'b0;
        func <= '0;
        motor_mask <= '0;
        speed_a <= '0;
        speed_b <= '0;
        dir_a <= '0;
        dir_b <= '0;
        cfg_valid <= 1'b0;
        cfg_addr <= '0;
        cfg_wdata <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // driver still disabled: nothing comes out
        send_cmd(mk_cmd(FUNC_BOTH, 8'h03, 8'd200, 8'd100, 8'd0, 8'd1));
        send_cmd(mk_cmd(FUNC_STOP, 8'h00, 8'd0, 8'd0, 8'd0, 8'd0));
        drain();
        cfg_write(CFG_ENABLE, 12'd1);

        send_cmd(mk_cmd(FUNC_SPEED, 8'h03, 8'd255, 8'd0, 8'd0, 8'd0));
        send_cmd(mk_cmd(FUNC_DIR, 8'h03, 8'd0, 8'd0, 8'd0, 8'd1));
        send_cmd(mk_cmd(FUNC_SPEED, 8'h03, 8'd255, 8'd255, 8'd0, 8'd0));
        send_cmd(mk_cmd(FUNC_DIR, 8'h01, 8'd0, 8'd0, 8'd3, 8'd0));
        send_cmd(mk_cmd(FUNC_DIR, 8'h02, 8'd0, 8'd0, 8'd0, 8'd4));
        send_cmd(mk_cmd(FUNC_BOTH, 8'h03, 8'd128, 8'd7, 8'd255, 8'd2));
        send_cmd(mk_cmd(FUNC_DIFF, 8'h00, 8'd200, 8'd100, 8'd1, 8'd0));
        send_cmd(mk_cmd(FUNC_DIFF, 8'hFC, 8'd1, 8'd254, 8'd170, 8'd85));
        send_cmd(mk_cmd(FUNC_STOP, 8'h00, 8'd255, 8'd255, 8'd1, 8'd1));
        send_cmd(mk_cmd(3'd5, 8'h03, 8'd255, 8'd255, 8'd0, 8'd0));
        send_cmd(mk_cmd(3'd6, 8'hFF, 8'd255, 8'd255, 8'd1, 8'd1));
        send_cmd(mk_cmd(3'd7, 8'hFF, 8'd255, 8'd255, 8'd0, 8'd0));
        send_cmd(mk_cmd(FUNC_SPEED, 8'hFC, 8'd99, 8'd99, 8'd0, 8'd0));
        send_cmd(mk_cmd(FUNC_BOTH, 8'hFF, 8'd1, 8'd254, 8'd0, 8'd1));
        send_cmd(mk_cmd(FUNC_BOTH, 8'h01, 8'd77, 8'd0, 8'd3, 8'd0));
        send_cmd(mk_cmd(FUNC_BOTH, 8'h02, 8'd0, 8'd255, 8'd0, 8'd128));
        send_cmd(mk_cmd(FUNC_DIR, 8'h00, 8'd0, 8'd0, 8'd0, 8'd1));
        send_cmd(mk_cmd(FUNC_STOP, 8'hFF, 8'd0, 8'd0, 8'd0, 8'd0));
        drain();

        set_limits(12'd0, 12'd4095);
        send_cmd(mk_cmd(FUNC_BOTH, 8'h03, 8'd255, 8'd255, 8'd0, 8'd1));
        run_random(60);
        drain();

        tx_idle_pct = 59;
        set_limits(12'd4095, 12'd0);
        send_cmd(mk_cmd(FUNC_BOTH, 8'h03, 8'd255, 8'd255, 8'd0, 8'd1));
        run_random(30);
        drain();
        set_limits(12'd1234, 12'd1234);
        run_random(30);
        drain();

        tx_idle_pct = 0;
        rx_stall_pct = 59;
        set_limits(12'd1000, 12'd3000);
        run_random(60);
        drain();
        cfg_write(CFG_ENABLE, 12'd0);
        run_random(10);
        drain();
        cfg_write(CFG_ENABLE, 12'd1);

        tx_idle_pct = 24;
        rx_stall_pct = 24;
        set_limits(12'd205, 12'd410);
        run_random(40);
        drain();
        run_random(40);
        drain();

        tx_idle_pct = 0;
        rx_stall_pct = 0;
        set_limits(12'($urandom_range(4095)), 12'($urandom_range(4095)));
        run_random(40);
        drain();
        rx_stall_pct = 59;
        set_limits(12'($urandom_range(2047)), 12'($urandom_range(4095, 2048)));
        run_random(50);
        drain();
        rx_stall_pct = 0;

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
